FILE: sv/clo_pkg.sv
// Package for the coarse location obfuscator: field widths, fixed-point
// constants and the request/response types of the shared multiply/divide unit.
// No dependencies.
package clo_pkg;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int ACC_W   = 20;
    localparam int TIME_W  = 48;
    localparam int GAUSS_W = 16;

    localparam logic signed [63:0] E7           = 64'sd10000000;
    localparam logic signed [63:0] FULL_TURN    = 64'sd3600000000;
    localparam logic signed [63:0] HALF_TURN    = 64'sd1800000000;
    localparam logic signed [63:0] QUARTER_TURN = 64'sd900000000;
    localparam logic signed [63:0] ONE_Q30      = 64'sd1073741824;
    localparam logic signed [63:0] HALF_PI_Q30  = 64'sd1686629713;
    localparam logic signed [63:0] PREV_W       = 64'sd1073258531;
    localparam logic signed [63:0] NEW_W        = 64'sd32212255;
    localparam logic signed [63:0] COS_FLOOR    = 64'sd65536;
    localparam logic [ACC_W-1:0]   ACC_MIN      = 20'd200;
    localparam logic [ACC_W-1:0]   ACC_RESET    = 20'd2000;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic [63:0]        b;
        logic [63:0]        d;
    } md_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] q;
        logic [63:0]        rem;
    } md_rsp_t;

    // ONE_Q30 * (2n-1) * 2n for the Taylor term n
    function automatic logic [63:0] cos_den(input logic [3:0] n);
        logic [63:0] k;
        begin
            case (n)
                4'd1:    k = 64'd2;
                4'd2:    k = 64'd12;
                4'd3:    k = 64'd30;
                4'd4:    k = 64'd56;
                4'd5:    k = 64'd90;
                4'd6:    k = 64'd132;
                4'd7:    k = 64'd182;
                default: k = 64'd240;
            endcase
            return k << 30;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            else if (v < -64'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

endpackage

FILE: sv/clo_if.sv
// Valid/ready channel interfaces for position fixes in and coarse fixes out.
// Depends on clo_pkg.
interface clo_in_if;
    import clo_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [LAT_W-1:0]   lat_in;
    logic signed [LON_W-1:0]   lon_in;
    logic [ACC_W-1:0]          accuracy_in;
    logic [TIME_W-1:0]         time_ms;
    logic signed [GAUSS_W-1:0] gauss_lat;
    logic signed [GAUSS_W-1:0] gauss_lon;

    modport source (output valid, lat_in, lon_in, accuracy_in, time_ms, gauss_lat, gauss_lon,
                    input ready);
    modport sink (input valid, lat_in, lon_in, accuracy_in, time_ms, gauss_lat, gauss_lon,
                  output ready);
endinterface

interface clo_out_if;
    import clo_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] lat_out;
    logic signed [LON_W-1:0] lon_out;
    logic [ACC_W-1:0]        accuracy_out;

    modport source (output valid, lat_out, lon_out, accuracy_out, input ready);
    modport sink (input valid, lat_out, lon_out, accuracy_out, output ready);
endinterface

FILE: sv/coarse_location_obfuscator.sv
// Coarse location obfuscator top level: sequencer around one shared multiply/divide unit.
// Depends on clo_pkg, clo_if and clo_muldiv.
//
// Each accepted fix is worked through 34 to 40 round(a*b/d) operations on one bit-serial
// unit (shift-add multiply, then restoring divide, the divide skipped when d is 1),
// among them the two 8-term cosine series. Input is not ready while a fix is being
// worked; a finished result waits in the output register while the next fix is taken.
// Register writes take effect on the next fix and never touch the stored drift offsets.
module coarse_location_obfuscator #(
    parameter int METERS_PER_DEGREE = 111000,
    parameter int CHANGE_PERIOD_MS  = 3600000,
    parameter int COS_TABLE_DEPTH   = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [clo_pkg::ACC_W-1:0] cfg_wdata,
    clo_in_if.sink                  fix_in,
    clo_out_if.source               fix_out
);
    import clo_pkg::*;

    localparam logic signed [63:0] MPD    = 64'(METERS_PER_DEGREE);
    localparam logic signed [63:0] LATMAX =
        QUARTER_TURN - 64'((10000000 + METERS_PER_DEGREE - 1) / METERS_PER_DEGREE);
    localparam logic [TIME_W-1:0]  PERIOD = TIME_W'(CHANGE_PERIOD_MS);
    localparam logic signed [63:0] DEPTH  = 64'(COS_TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_SEED_N, S_SEED_E, S_BL_N1, S_BL_N2, S_BL_N3, S_BL_E1, S_BL_E2, S_BL_E3,
        S_C_K, S_C_TH, S_C_T2, S_C_LOOP, S_T_E, S_DLON, S_DLAT, S_WRAP1, S_AE, S_SN1,
        S_SN2, S_G0, S_G1, S_LN1, S_LN2, S_WRAP2, S_DONE
    } state_t;

    function automatic logic signed [63:0] clamp_lat(input logic signed [63:0] v);
        begin
            if (v > LATMAX)
                return LATMAX;
            else if (v < -LATMAX)
                return -LATMAX;
            else
                return v;
        end
    endfunction

    function automatic logic signed [63:0] wrap_fix(input logic neg, input logic [63:0] r);
        logic signed [63:0] v;
        begin
            v = $signed(r);
            if (neg && (r != 64'd0))
                v = FULL_TURN - v;
            if (v >= HALF_TURN)
                v = v - FULL_TURN;
            return v;
        end
    endfunction

    state_t                    state_reg;
    logic                      pend_reg;
    logic                      cos2_reg;
    logic [ACC_W-1:0]          cfg_acc_reg;
    logic [ACC_W-1:0]          a_reg;
    logic [ACC_W-1:0]          acc_in_reg;
    logic [TIME_W-1:0]         now_reg;
    logic signed [GAUSS_W-1:0] gl_reg;
    logic signed [GAUSS_W-1:0] go_reg;
    logic signed [63:0]        lat_reg;
    logic signed [63:0]        lon_reg;
    logic signed [63:0]        x_reg;
    logic signed [63:0]        y_reg;
    logic signed [63:0]        term_reg;
    logic signed [63:0]        sum_reg;
    logic [63:0]               t2_reg;
    logic [63:0]               c_reg;
    logic [63:0]               ae_reg;
    logic [63:0]               g_reg;
    logic [3:0]                n_reg;
    logic signed [31:0]        on_reg;
    logic signed [31:0]        oe_reg;
    logic [TIME_W-1:0]         nxt_reg;
    logic                      seeded_reg;
    logic                      out_valid_reg;
    logic signed [LAT_W-1:0]   lat_out_reg;
    logic signed [LON_W-1:0]   lon_out_reg;
    logic [ACC_W-1:0]          acc_out_reg;

    md_req_t            md_req;
    md_rsp_t            md_rsp;
    logic               op_st;
    logic               fire;
    logic signed [63:0] q;
    logic signed [63:0] lat_abs;
    logic signed [63:0] lat_sx;
    logic signed [63:0] lon_sx;
    logic signed [63:0] lon_w;
    logic signed [63:0] sum_new;
    logic [ACC_W-1:0]   a_cur;

    clo_muldiv u_md (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign op_st   = (state_reg != S_IDLE) && (state_reg != S_DONE);
    assign fire    = pend_reg && md_rsp.done;
    assign q       = md_rsp.q;
    assign lat_abs = (lat_reg < 0) ? -lat_reg : lat_reg;
    assign lat_sx  = 64'(fix_in.lat_in);
    assign lon_sx  = 64'(fix_in.lon_in);
    assign a_cur   = (cfg_acc_reg < ACC_MIN) ? ACC_MIN : cfg_acc_reg;
    assign sum_new = sum_reg - q;

    always_comb
    begin
        if (lon_sx >= HALF_TURN)
            lon_w = lon_sx - FULL_TURN;
        else if (lon_sx < -HALF_TURN)
            lon_w = lon_sx + FULL_TURN;
        else
            lon_w = lon_sx;
    end

    always_comb
    begin
        md_req.start = op_st && !pend_reg;
        md_req.a     = '0;
        md_req.b     = 64'd1;
        md_req.d     = 64'd1;
        unique case (state_reg)
            S_SEED_N: begin md_req.a = 64'(gl_reg); md_req.b = 64'(a_reg); md_req.d = 64'd64; end
            S_SEED_E: begin md_req.a = 64'(go_reg); md_req.b = 64'(a_reg); md_req.d = 64'd64; end
            S_BL_N1:  begin md_req.a = 64'(on_reg); md_req.b = PREV_W; md_req.d = ONE_Q30; end
            S_BL_N2:  begin md_req.a = 64'(gl_reg); md_req.b = 64'(a_reg); end
            S_BL_N3:  begin md_req.a = x_reg; md_req.b = NEW_W; md_req.d = 64'd1 << 36; end
            S_BL_E1:  begin md_req.a = 64'(oe_reg); md_req.b = PREV_W; md_req.d = ONE_Q30; end
            S_BL_E2:  begin md_req.a = 64'(go_reg); md_req.b = 64'(a_reg); end
            S_BL_E3:  begin md_req.a = x_reg; md_req.b = NEW_W; md_req.d = 64'd1 << 36; end
            S_C_K:    begin md_req.a = lat_abs; md_req.b = DEPTH; md_req.d = QUARTER_TURN; end
            S_C_TH:   begin md_req.a = x_reg; md_req.b = HALF_PI_Q30; md_req.d = DEPTH; end
            S_C_T2:   begin md_req.a = x_reg; md_req.b = x_reg; md_req.d = ONE_Q30; end
            S_C_LOOP: begin md_req.a = term_reg; md_req.b = t2_reg; md_req.d = cos_den(n_reg); end
            S_T_E:    begin md_req.a = 64'(oe_reg); md_req.b = E7; md_req.d = MPD; end
            S_DLON:   begin md_req.a = x_reg; md_req.b = 64'd1 << 22; md_req.d = c_reg; end
            S_DLAT:   begin md_req.a = 64'(on_reg); md_req.b = E7; md_req.d = MPD * 256; end
            S_WRAP1,
            S_WRAP2:  begin md_req.a = lon_reg; md_req.d = FULL_TURN; end
            S_AE:     begin md_req.a = 64'(a_reg); md_req.b = E7; end
            S_SN1:    begin md_req.a = lat_reg; md_req.b = MPD; md_req.d = ae_reg; end
            S_SN2:    begin md_req.a = x_reg; md_req.b = ae_reg; md_req.d = MPD; end
            S_G0:     begin md_req.a = $signed(ae_reg); md_req.b = 64'd256; md_req.d = MPD; end
            S_G1:     begin md_req.a = x_reg; md_req.b = ONE_Q30; md_req.d = c_reg; end
            S_LN1:    begin md_req.a = lon_reg; md_req.b = 64'd256; md_req.d = g_reg; end
            S_LN2:    begin md_req.a = x_reg; md_req.b = g_reg; md_req.d = 64'd256; end
            default:  begin md_req.a = '0; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            cos2_reg      <= 1'b0;
            cfg_acc_reg   <= ACC_RESET;
            on_reg        <= '0;
            oe_reg        <= '0;
            nxt_reg       <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_acc_reg <= cfg_wdata;
            if (out_valid_reg && fix_out.ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;
            if (op_st && !pend_reg)
                pend_reg <= 1'b1;
            if (fire)
                pend_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (fix_in.valid)
                    begin
                        lat_reg    <= clamp_lat(lat_sx);
                        lon_reg    <= lon_w;
                        a_reg      <= a_cur;
                        acc_in_reg <= fix_in.accuracy_in;
                        now_reg    <= fix_in.time_ms;
                        gl_reg     <= fix_in.gauss_lat;
                        go_reg     <= fix_in.gauss_lon;
                        cos2_reg   <= 1'b0;
                        if (!seeded_reg)
                            state_reg <= S_SEED_N;
                        else if (fix_in.time_ms >= nxt_reg)
                        begin
                            nxt_reg   <= fix_in.time_ms + PERIOD;
                            state_reg <= S_BL_N1;
                        end
                        else
                            state_reg <= S_C_K;
                    end
                end
                S_SEED_N: if (fire) begin on_reg <= sat32(q); state_reg <= S_SEED_E; end
                S_SEED_E:
                begin
                    if (fire)
                    begin
                        oe_reg     <= sat32(q);
                        nxt_reg    <= now_reg + PERIOD;
                        seeded_reg <= 1'b1;
                        state_reg  <= S_C_K;
                    end
                end
                S_BL_N1: if (fire) begin y_reg <= q; state_reg <= S_BL_N2; end
                S_BL_N2: if (fire) begin x_reg <= q; state_reg <= S_BL_N3; end
                S_BL_N3: if (fire) begin on_reg <= sat32(y_reg + q); state_reg <= S_BL_E1; end
                S_BL_E1: if (fire) begin y_reg <= q; state_reg <= S_BL_E2; end
                S_BL_E2: if (fire) begin x_reg <= q; state_reg <= S_BL_E3; end
                S_BL_E3: if (fire) begin oe_reg <= sat32(y_reg + q); state_reg <= S_C_K; end
                S_C_K:
                begin
                    if (fire)
                    begin
                        x_reg     <= (q > DEPTH - 1) ? DEPTH - 1 : q;
                        state_reg <= S_C_TH;
                    end
                end
                S_C_TH: if (fire) begin x_reg <= q; state_reg <= S_C_T2; end
                S_C_T2:
                begin
                    if (fire)
                    begin
                        t2_reg    <= q;
                        term_reg  <= ONE_Q30;
                        sum_reg   <= ONE_Q30;
                        n_reg     <= 4'd1;
                        state_reg <= S_C_LOOP;
                    end
                end
                S_C_LOOP:
                begin
                    if (fire)
                    begin
                        term_reg <= -q;
                        sum_reg  <= sum_new;
                        n_reg    <= n_reg + 4'd1;
                        if (n_reg == 4'd8)
                        begin
                            if (sum_new < COS_FLOOR)
                                c_reg <= COS_FLOOR;
                            else if (sum_new > ONE_Q30)
                                c_reg <= ONE_Q30;
                            else
                                c_reg <= sum_new;
                            state_reg <= cos2_reg ? S_G0 : S_T_E;
                        end
                    end
                end
                S_T_E:  if (fire) begin x_reg <= q; state_reg <= S_DLON; end
                S_DLON: if (fire) begin lon_reg <= lon_reg + q; state_reg <= S_DLAT; end
                S_DLAT: if (fire) begin lat_reg <= clamp_lat(lat_reg + q); state_reg <= S_WRAP1; end
                S_WRAP1:
                begin
                    if (fire)
                    begin
                        lon_reg   <= wrap_fix(lon_reg < 0, md_rsp.rem);
                        state_reg <= S_AE;
                    end
                end
                S_AE:  if (fire) begin ae_reg <= q; state_reg <= S_SN1; end
                S_SN1: if (fire) begin x_reg <= q; state_reg <= S_SN2; end
                S_SN2:
                begin
                    if (fire)
                    begin
                        lat_reg   <= q;
                        cos2_reg  <= 1'b1;
                        state_reg <= S_C_K;
                    end
                end
                S_G0:  if (fire) begin x_reg <= q; state_reg <= S_G1; end
                S_G1:  if (fire) begin g_reg <= (q < 1) ? 64'd1 : q; state_reg <= S_LN1; end
                S_LN1: if (fire) begin x_reg <= q; state_reg <= S_LN2; end
                S_LN2: if (fire) begin lon_reg <= q; state_reg <= S_WRAP2; end
                S_WRAP2:
                begin
                    if (fire)
                    begin
                        lon_reg   <= wrap_fix(lon_reg < 0, md_rsp.rem);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || fix_out.ready)
                    begin
                        lat_out_reg   <= LAT_W'(clamp_lat(lat_reg));
                        lon_out_reg   <= lon_reg[LON_W-1:0];
                        acc_out_reg   <= (acc_in_reg > a_reg) ? acc_in_reg : a_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign fix_in.ready         = (state_reg == S_IDLE);
    assign fix_out.valid        = out_valid_reg;
    assign fix_out.lat_out      = lat_out_reg;
    assign fix_out.lon_out      = lon_out_reg;
    assign fix_out.accuracy_out = acc_out_reg;

    a_md_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("shared unit started while busy");

    a_acc_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (acc_out_reg >= ACC_MIN))
        else $error("reported accuracy below floor");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (64'(lat_out_reg) <= LATMAX && 64'(lat_out_reg) >= -LATMAX))
        else $error("latitude out of clamp range");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !fix_out.ready) |=> (state_reg == S_DONE))
        else $error("result overwritten before transaction");

endmodule

FILE: sv/clo_muldiv.sv
// Shared bit-serial unit: q = round(a*b/d), ties away from zero, plus the raw
// remainder of |a*b|/d. Shift-add multiply, then restoring divide.
// Depends on clo_pkg.
module clo_muldiv (
    input  logic              clk,
    input  logic              rst_n,
    input  clo_pkg::md_req_t  req,
    output clo_pkg::md_rsp_t  rsp
);
    import clo_pkg::*;

    typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} ust_t;

    ust_t        st_reg;
    logic        neg_reg;
    logic [95:0] mcand_reg;
    logic [95:0] acc_reg;
    logic [63:0] mplier_reg;
    logic [63:0] d_reg;
    logic [63:0] rem_reg;
    logic [6:0]  cnt_reg;

    logic [64:0] rem_sh;
    logic [64:0] rem_diff;
    logic        rnd_up;
    logic [95:0] q_rnd;
    logic [63:0] a_mag;

    assign a_mag    = req.a[63] ? 64'(-req.a) : 64'(req.a);
    assign rem_sh   = {rem_reg, acc_reg[95]};
    assign rem_diff = rem_sh - {1'b0, d_reg};
    assign rnd_up   = ({rem_reg, 1'b0} >= {1'b0, d_reg});
    assign q_rnd    = acc_reg + {95'd0, rnd_up};

    assign rsp.busy = (st_reg != U_IDLE);
    assign rsp.done = (st_reg == U_FIN);
    assign rsp.q    = neg_reg ? -$signed(q_rnd[63:0]) : $signed(q_rnd[63:0]);
    assign rsp.rem  = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= U_IDLE;
        end
        else
        begin
            unique case (st_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        neg_reg    <= req.a[63];
                        mcand_reg  <= {32'd0, a_mag};
                        mplier_reg <= req.b;
                        d_reg      <= req.d;
                        acc_reg    <= '0;
                        rem_reg    <= '0;
                        st_reg     <= U_MUL;
                    end
                end
                U_MUL:
                begin
                    if (mplier_reg == 64'd0)
                    begin
                        cnt_reg <= '0;
                        st_reg  <= (d_reg == 64'd1) ? U_FIN : U_DIV;
                    end
                    else
                    begin
                        if (mplier_reg[0])
                            acc_reg <= acc_reg + mcand_reg;
                        mcand_reg  <= {mcand_reg[94:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[63:1]};
                    end
                end
                U_DIV:
                begin
                    rem_reg <= rem_diff[64] ? rem_sh[63:0] : rem_diff[63:0];
                    acc_reg <= {acc_reg[94:0], ~rem_diff[64]};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd95)
                        st_reg <= U_FIN;
                end
                U_FIN:
                begin
                    st_reg <= U_IDLE;
                end
                default:
                begin
                    st_reg <= U_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/coarse_location_obfuscator_tb.sv
// Self-checking testbench for coarse_location_obfuscator: directed fixes, then random fixes
// under several accuracy settings, compared against a coarsening predictor or known results.
// Depends on clo_pkg, clo_if and the coarse_location_obfuscator RTL.
module coarse_location_obfuscator_tb;
    import clo_pkg::*;

    localparam longint MPD       = 111000;
    localparam longint PERIOD_MS = 3600000;
    localparam longint DEPTH     = 1024;
    localparam longint LAT_LIM   = 64'd900000000 - (64'd10000000 + MPD - 1) / MPD;
    localparam longint MASK_48   = 64'hFFFF_FFFF_FFFF;
    localparam int     NPHASE    = 7;
    localparam int     PHASE_LEN = 192;

    typedef struct {
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        logic [ACC_W-1:0]        acc;
    } coarse_fix_t;

    typedef struct {
        logic signed [LAT_W-1:0]   lat;
        logic signed [LON_W-1:0]   lon;
        logic [ACC_W-1:0]          acc;
        logic [TIME_W-1:0]         tms;
        logic signed [GAUSS_W-1:0] g_lat;
        logic signed [GAUSS_W-1:0] g_lon;
        bit                        known;
        coarse_fix_t               want;
    } fix_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [ACC_W-1:0] cfg_wdata;

    clo_in_if  in_ch();
    clo_out_if out_ch();

    coarse_location_obfuscator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fix_in    (in_ch),
        .fix_out   (out_ch)
    );

    // predictor state
    logic [ACC_W-1:0]  acc_cfg;
    logic signed [31:0] drift_n;
    logic signed [31:0] drift_e;
    logic [TIME_W-1:0] next_ms;
    bit                drift_seeded;

    coarse_fix_t expected_fixes[$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_cfg;
    int          hold_req;
    bit          burst_mode;

    fix_row_t directed[12];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("timeout after %0d results", n_checked);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint rdiv(longint n, longint d);
        longint unsigned m;
        longint unsigned q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint scale_div(longint a, int sh, longint d);
        longint unsigned m;
        longint unsigned q;
        longint unsigned r;
        longint unsigned res;
        m = (a < 0) ? -a : a;
        q = m / d;
        r = m % d;
        res = (q << sh) + ((r << sh) + d / 2) / d;
        return (a < 0) ? -longint'(res) : longint'(res);
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint lat_clamp(longint v);
        if (v > LAT_LIM)
            return LAT_LIM;
        if (v < -LAT_LIM)
            return -LAT_LIM;
        return v;
    endfunction

    function automatic longint lon_wrap(longint v);
        longint r;
        r = v % longint'(FULL_TURN);
        if (r < 0)
            r += longint'(FULL_TURN);
        if (r >= longint'(HALF_TURN))
            r -= longint'(FULL_TURN);
        return r;
    endfunction

    function automatic longint cosine_q30(longint lat);
        longint a;
        longint k;
        longint th;
        longint t2;
        longint term;
        longint sum;
        a = (lat < 0) ? -lat : lat;
        k = rdiv(a * DEPTH, longint'(QUARTER_TURN));
        if (k > DEPTH - 1)
            k = DEPTH - 1;
        th = rdiv(k * longint'(HALF_PI_Q30), DEPTH);
        t2 = rdiv(th * th, longint'(ONE_Q30));
        term = ONE_Q30;
        sum = term;
        for (int n = 1; n <= 8; n++)
        begin
            term = -rdiv(term * t2, longint'(ONE_Q30) * ((2 * n - 1) * (2 * n)));
            sum += term;
        end
        if (sum < longint'(COS_FLOOR))
            sum = COS_FLOOR;
        if (sum > longint'(ONE_Q30))
            sum = ONE_Q30;
        return sum;
    endfunction

    function automatic coarse_fix_t coarsen(fix_row_t f);
        coarse_fix_t r;
        longint lat;
        longint lon;
        longint a;
        longint gl;
        longint ge;
        longint c;
        longint t;
        longint n;
        longint g;
        longint unsigned now;
        a = (acc_cfg < ACC_MIN) ? 64'sd200 : longint'(acc_cfg);
        lat = lat_clamp(longint'(f.lat));
        lon = lon_wrap(longint'(f.lon));
        gl = longint'(f.g_lat);
        ge = longint'(f.g_lon);
        now = 64'(f.tms);
        if (!drift_seeded)
        begin
            drift_n = 32'(sat_s32(rdiv(gl * a, 64)));
            drift_e = 32'(sat_s32(rdiv(ge * a, 64)));
            next_ms = TIME_W'((now + PERIOD_MS) & MASK_48);
            drift_seeded = 1'b1;
        end
        else if (now >= longint'(next_ms))
        begin
            next_ms = TIME_W'((now + PERIOD_MS) & MASK_48);
            drift_n = 32'(sat_s32(rdiv(longint'(drift_n) * longint'(PREV_W), longint'(ONE_Q30))
                              + rdiv(gl * a * longint'(NEW_W), longint'(ONE_Q30) * 64)));
            drift_e = 32'(sat_s32(rdiv(longint'(drift_e) * longint'(PREV_W), longint'(ONE_Q30))
                              + rdiv(ge * a * longint'(NEW_W), longint'(ONE_Q30) * 64)));
        end
        c = cosine_q30(lat);
        t = rdiv(longint'(drift_e) * longint'(E7), MPD);
        lon += scale_div(t, 22, c);
        lat += rdiv(longint'(drift_n) * longint'(E7), 256 * MPD);
        lat = lat_clamp(lat);
        lon = lon_wrap(lon);
        n = rdiv(lat * MPD, a * longint'(E7));
        lat = rdiv(n * a * longint'(E7), MPD);
        c = cosine_q30(lat);
        g = scale_div(rdiv(a * longint'(E7) * 256, MPD), 30, c);
        if (g < 1)
            g = 1;
        n = rdiv(lon * 256, g);
        lon = rdiv(n * g, 256);
        r.lat = LAT_W'(lat_clamp(lat));
        r.lon = LON_W'(lon_wrap(lon));
        r.acc = ACC_W'((longint'(f.acc) > a) ? longint'(f.acc) : a);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    task automatic offer(fix_row_t f, int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.lat_in      <= f.lat;
        in_ch.lon_in      <= f.lon;
        in_ch.accuracy_in <= f.acc;
        in_ch.time_ms     <= f.tms;
        in_ch.gauss_lat   <= f.g_lat;
        in_ch.gauss_lon   <= f.g_lon;
        do
            @(posedge clk);
        while (!in_ch.ready);
        begin
            coarse_fix_t p;
            p = coarsen(f);
            expected_fixes.push_back(f.known ? f.want : p);
        end
        n_sent++;
    endtask

    task automatic drain();
        @(posedge clk);
        in_ch.valid <= 1'b0;
        while (expected_fixes.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_accuracy(logic [ACC_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we  <= 1'b0;
        acc_cfg = v;
        n_cfg++;
    endtask

    // receiver
    initial
    begin
        int w;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req > 0)
            begin
                w = hold_req;
                hold_req = 0;
            end
            else
                w = burst_mode ? 0 : $urandom_range(0, 16);
            if (w > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            n_checked++;
            if (expected_fixes.size() == 0)
                report("unexpected transaction lat", out_ch.lat_out, 0);
            else
            begin
                coarse_fix_t e;
                e = expected_fixes.pop_front();
                if (out_ch.lat_out !== e.lat)
                    report("lat_out", out_ch.lat_out, e.lat);
                if (out_ch.lon_out !== e.lon)
                    report("lon_out", out_ch.lon_out, e.lon);
                if (out_ch.accuracy_out !== e.acc)
                    report("accuracy_out", out_ch.accuracy_out, e.acc);
            end
        end
    end

    initial
    begin
        fix_row_t f;
        logic [TIME_W-1:0] now;
        logic [ACC_W-1:0] settings[NPHASE];
        int sel;

        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_cfg = 0;
        hold_req = 0;
        burst_mode = 1'b0;
        acc_cfg = ACC_RESET;
        drift_n = 0;
        drift_e = 0;
        next_ms = 0;
        drift_seeded = 1'b0;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.lat_in      <= '0;
        in_ch.lon_in      <= '0;
        in_ch.accuracy_in <= '0;
        in_ch.time_ms     <= '0;
        in_ch.gauss_lat   <= '0;
        in_ch.gauss_lon   <= '0;

        //             lat          lon          acc      time  g_lat   g_lon   known  want
        directed[0]  = '{0, 0, 0, 0, 0, 0, 1, '{0, 0, 2000}};
        directed[1]  = '{0, 0, 1000000, 1, 0, 0, 1, '{0, 0, 1000000}};
        directed[2]  = '{900000000, 0, 0, 2, 32767, -32768, 0, '{0, 0, 0}};
        directed[3]  = '{-900000000, -1800000000, 5, 3, 0, 0, 0, '{0, 0, 0}};
        directed[4]  = '{0, 1800000000, 2001, 4, 0, 0, 0, '{0, 0, 0}};
        directed[5]  = '{455000000, 1234567890, 300, 3600000, 32767, 32767, 0, '{0, 0, 0}};
        directed[6]  = '{-455000000, -1234567890, 0, 7200000, -32768, -32768, 0, '{0, 0, 0}};
        directed[7]  = '{899999999, 1799999999, 200, 7200001, 0, 0, 0, '{0, 0, 0}};
        directed[8]  = '{-899999999, -1, 1048575 % 1000001, 10800000, 4096, -4096, 0,
                         '{0, 0, 0}};
        directed[9]  = '{1, 2, 999999, 48'hFFFF_FFFF_FFFF, 32767, -32768, 0, '{0, 0, 0}};
        directed[10] = '{-1, -2, 0, 0, 100, 100, 0, '{0, 0, 0}};
        directed[11] = '{899999909, -1800000000, 0, 3600000, -32768, 32767, 0, '{0, 0, 0}};

        settings[0] = 20'd0;
        settings[1] = 20'd1000000;
        settings[2] = 20'd199;
        settings[3] = 20'd200;
        settings[4] = ACC_W'($urandom_range(201, 999999));
        settings[5] = ACC_W'($urandom_range(200, 5000));
        settings[6] = ACC_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            offer(directed[i], $urandom_range(0, 3));
        drain();

        now = 20000000;
        for (int p = 0; p < NPHASE; p++)
        begin
            write_accuracy(settings[p]);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                if ($urandom_range(0, 39) == 0)
                    burst_mode = ~burst_mode;
                if (p == 1 && i == 20)
                    hold_req = 30000;
                sel = $urandom_range(0, 9);
                f.lat = LAT_W'((sel < 6) ? $signed($urandom_range(0, 1800000000)) - 900000000
                      : (sel < 8) ? ($urandom_range(0, 1) ? 1 : -1) *
                                    (900000000 - $signed($urandom_range(0, 20000)))
                      : $signed($urandom_range(0, 2000000)) - 1000000);
                f.lon = LON_W'(longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000);
                f.acc = ACC_W'($urandom_range(0, 5) == 0 ? $urandom_range(0, 1000000)
                                                         : $urandom_range(0, 3000));
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    now = TIME_W'({$urandom(), $urandom()});
                else if (sel < 6)
                    now = now + $urandom_range(3600000, 8000000);
                else
                    now = now + $urandom_range(0, 300000);
                f.tms = now;
                f.g_lat = GAUSS_W'($urandom());
                f.g_lon = GAUSS_W'($urandom());
                f.known = 1'b0;
                f.want = '{0, 0, 0};
                offer(f, burst_mode ? 0 : $urandom_range(0, 16));
            end
            burst_mode = 1'b0;
            drain();
        end

        $display("%0d fixes sent, %0d results checked, %0d accuracy settings, one long stall",
                 n_sent, n_checked, n_cfg);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
